@@ hw/rtl/tvg_pkg.sv @@
// Shared constants, codes and types of the total-variation gradient block.
package tvg_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int PIXEL_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DIM_BITS       = 11;
   localparam int EPS_BITS       = 16;
   localparam int PIXEL_IN_BITS  = 16;
   localparam int GRAD_BITS      = 16;
   localparam int POS_BITS       = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EPSILON      = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [1:0] TERM_CENTER = 2'd0;
   localparam logic [1:0] TERM_DOWN   = 2'd1;
   localparam logic [1:0] TERM_RIGHT  = 2'd2;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET   = 11'd256;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET  = 11'd256;
   localparam logic [EPS_BITS-1:0] EPSILON_RESET = 16'd1;
   localparam int MAX_HEIGHT = 1024;

   // Position of the pixel whose result the line buffer hands on.
   typedef struct packed {
      logic                emit;
      logic                last;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] column;
   } pos_type;

   // Numerator width: 4P - 2U - 2L of signed pixels.
   function automatic int num_width(input int pixel_bits);
      return pixel_bits + 3;
   endfunction

   // Signed width of one rounded term.
   function automatic int term_width(input int pixel_bits);
      return pixel_bits + 26;
   endfunction

endpackage

@@ hw/rtl/tvg_req_if.sv @@
// Request channel: one pixel or flush word per handshake.
interface tvg_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       command;
   logic signed [tvg_pkg::PIXEL_IN_BITS-1:0]   pixel;

   modport source(output valid, output command, output pixel, input ready);
   modport sink(input valid, input command, input pixel, output ready);
endinterface

@@ hw/rtl/tvg_rsp_if.sv @@
// Response channel: one gradient word per handshake.
interface tvg_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tvg_pkg::GRAD_BITS-1:0]   gradient;
   logic [tvg_pkg::POS_BITS-1:0]           row;
   logic [tvg_pkg::POS_BITS-1:0]           column;
   logic                                   last;

   modport source(output valid, output gradient, output row, output column, output last,
                  input ready);
   modport sink(input valid, input gradient, input row, input column, input last,
                output ready);
endinterface

@@ hw/rtl/tvg_line_buf.sv @@
// Two line memories, the tap window and the position counters of the stencil.
module tvg_line_buf #(
   parameter int MAX_WIDTH  = tvg_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = tvg_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [PIXEL_BITS-1:0]         x,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       w,
   input  logic [tvg_pkg::DIM_BITS-1:0]         h,
   output logic                                 clearing,
   output logic                                 done,
   output tvg_pkg::pos_type                     info,
   output logic signed [PIXEL_BITS-1:0]         p,
   output logic signed [PIXEL_BITS-1:0]         up,
   output logic signed [PIXEL_BITS-1:0]         ur,
   output logic signed [PIXEL_BITS-1:0]         lf,
   output logic signed [PIXEL_BITS-1:0]         rt,
   output logic signed [PIXEL_BITS-1:0]         dn,
   output logic signed [PIXEL_BITS-1:0]         dl
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int FW = $clog2(MAX_WIDTH+2);
   localparam int RB = tvg_pkg::DIM_BITS;

   typedef enum logic {LB_IDLE, LB_UPDATE} state_type;

   logic signed [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
   logic signed [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];

   state_type                    state_ff;
   logic                         clearing_ff;
   logic [AW-1:0]                clear_addr_ff;
   logic [AW-1:0]                line_addr_ff;
   logic [AW-1:0]                addr_ff;
   logic [AW-1:0]                rd_addr;
   logic signed [PIXEL_BITS-1:0] x_ff;
   logic signed [PIXEL_BITS-1:0] d1_ff;
   logic signed [PIXEL_BITS-1:0] d2_ff;
   logic signed [PIXEL_BITS-1:0] win_ff [5];
   logic [WW-1:0]                col_ff;
   logic [RB-1:0]                row_ff;
   logic [FW-1:0]                flush_ff;
   logic                         done_ff;
   tvg_pkg::pos_type             info_ff;
   logic signed [PIXEL_BITS-1:0] p_ff, up_ff, ur_ff, lf_ff, rt_ff, dn_ff, dl_ff;

   logic                         emit;
   logic                         has_up, has_down, has_left, has_right, is_last;
   logic [WW:0]                  col_next;
   logic [WW:0]                  addr_next;

   // A line address left beyond a narrowed width restarts at zero.
   assign rd_addr   = (WW'(line_addr_ff) >= w) ? '0 : line_addr_ff;
   assign emit      = flush_ff >= (FW'(w) + FW'(1));
   assign col_next  = (WW+1)'(col_ff) + (WW+1)'(1);
   assign addr_next = (WW+1)'(addr_ff) + (WW+1)'(1);
   assign has_up    = row_ff != '0;
   assign has_down  = ((RB+1)'(row_ff) + (RB+1)'(1)) < (RB+1)'(h);
   assign has_left  = col_ff != '0;
   assign has_right = col_next < (WW+1)'(w);
   assign is_last   = (row_ff == h - RB'(1)) && (col_next == (WW+1)'(w));

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_a[clear_addr_ff] <= '0;
         mem_b[clear_addr_ff] <= '0;
      end else if (state_ff == LB_UPDATE) begin
         mem_a[addr_ff] <= x_ff;
         mem_b[addr_ff] <= d1_ff;
      end
      if (start) begin
         d1_ff <= mem_a[rd_addr];
         d2_ff <= mem_b[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= LB_IDLE;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         line_addr_ff  <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         flush_ff      <= '0;
         done_ff       <= 1'b0;
         info_ff       <= '0;
         for (int i = 0; i < 5; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         done_ff <= 1'b0;
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(MAX_WIDTH-1)) begin
               clearing_ff <= 1'b0;
            end
         end
         case (state_ff)
            LB_IDLE: begin
               if (start) begin
                  addr_ff  <= rd_addr;
                  x_ff     <= x;
                  state_ff <= LB_UPDATE;
               end
            end
            LB_UPDATE: begin
               line_addr_ff <= (addr_next >= (WW+1)'(w)) ? '0 : AW'(addr_next);
               p_ff  <= win_ff[2];
               up_ff <= has_up ? win_ff[4] : '0;
               ur_ff <= (has_up && has_right) ? d2_ff : '0;
               lf_ff <= has_left ? win_ff[3] : '0;
               rt_ff <= has_right ? d1_ff : '0;
               dn_ff <= has_down ? win_ff[0] : '0;
               dl_ff <= (has_down && has_left) ? win_ff[1] : '0;
               info_ff.emit   <= emit;
               info_ff.last   <= is_last;
               info_ff.row    <= tvg_pkg::POS_BITS'(row_ff);
               info_ff.column <= tvg_pkg::POS_BITS'(col_ff);
               if (emit) begin
                  if (is_last) begin
                     row_ff   <= '0;
                     col_ff   <= '0;
                     flush_ff <= '0;
                  end else if (col_next >= (WW+1)'(w)) begin
                     col_ff <= '0;
                     row_ff <= row_ff + RB'(1);
                  end else begin
                     col_ff <= WW'(col_next);
                  end
               end else begin
                  flush_ff <= flush_ff + FW'(1);
               end
               win_ff[1] <= win_ff[0];
               win_ff[0] <= x_ff;
               win_ff[3] <= win_ff[2];
               win_ff[2] <= d1_ff;
               win_ff[4] <= d2_ff;
               done_ff   <= 1'b1;
               state_ff  <= LB_IDLE;
            end
            default: state_ff <= LB_IDLE;
         endcase
      end
   end

   assign clearing = clearing_ff;
   assign done     = done_ff;
   assign info     = info_ff;
   assign p  = p_ff;
   assign up = up_ff;
   assign ur = ur_ff;
   assign lf = lf_ff;
   assign rt = rt_ff;
   assign dn = dn_ff;
   assign dl = dl_ff;
endmodule

@@ hw/rtl/tvg_term.sv @@
// One stencil term: squares, bit-serial root and bit-serial rounded quotient.
module tvg_term #(
   parameter int PIXEL_BITS = tvg_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   start,
   input  logic signed [tvg_pkg::num_width(PIXEL_BITS)-1:0]       num,
   input  logic signed [PIXEL_BITS:0]                             dx,
   input  logic signed [PIXEL_BITS:0]                             dy,
   input  logic [tvg_pkg::EPS_BITS-1:0]                           epsilon,
   output logic                                                   done,
   output logic signed [tvg_pkg::term_width(PIXEL_BITS)-1:0]      term
);
   localparam int NW   = tvg_pkg::num_width(PIXEL_BITS);
   localparam int DW   = PIXEL_BITS + 1;
   localparam int SQW  = 2 * DW;
   localparam int SW   = 2 * PIXEL_BITS + 3;
   localparam int RW   = ((SW + 17) / 2) * 2;
   localparam int TW   = RW / 2;
   localparam int DVW  = TW + 1;
   localparam int XW   = NW + 22;
   localparam int OW   = tvg_pkg::term_width(PIXEL_BITS);
   localparam int CNTW = $clog2(XW);

   typedef enum logic [2:0] {
      S_IDLE, S_SQUARE, S_SUM, S_ROOT, S_SETUP, S_DIVIDE, S_FINISH
   } state_type;

   state_type             state_ff;
   logic                  done_ff;
   logic signed [OW-1:0]  term_ff;
   logic                  neg_ff;
   logic [NW-1:0]         mag_ff;
   logic signed [DW-1:0]  dx_ff, dy_ff;
   logic [SQW-1:0]        sqx_ff, sqy_ff;
   logic [RW-1:0]         rad_ff;
   logic [TW+1:0]         rem_ff;
   logic [TW-1:0]         root_ff;
   logic [XW-1:0]         xd_ff;
   logic [DVW-1:0]        dv_ff;
   logic [DVW-1:0]        drem_ff;
   logic [XW-1:0]         q_ff;
   logic [CNTW-1:0]       cnt_ff;

   logic [TW+3:0]         root_cat, root_trial;
   logic                  root_bit;
   logic [DVW:0]          div_cat;
   logic                  div_bit;

   assign root_cat   = {rem_ff, rad_ff[RW-1:RW-2]};
   assign root_trial = {2'b00, root_ff, 2'b01};
   assign root_bit   = root_cat >= root_trial;
   assign div_cat    = {drem_ff, xd_ff[XW-1]};
   assign div_bit    = div_cat >= {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (num == '0) begin
                     term_ff <= '0;
                     done_ff <= 1'b1;
                  end else begin
                     neg_ff   <= num < 0;
                     mag_ff   <= (num < 0) ? NW'(-num) : NW'(num);
                     dx_ff    <= dx;
                     dy_ff    <= dy;
                     state_ff <= S_SQUARE;
                  end
               end
            end
            S_SQUARE: begin
               // Operands are widened first so the product keeps all its bits.
               sqx_ff   <= $unsigned(SQW'(dx_ff) * SQW'(dx_ff));
               sqy_ff   <= $unsigned(SQW'(dy_ff) * SQW'(dy_ff));
               state_ff <= S_SUM;
            end
            S_SUM: begin
               rad_ff   <= RW'(SW'(epsilon) + SW'(sqx_ff) + SW'(sqy_ff)) << 16;
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= CNTW'(TW - 1);
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               // Two radicand bits enter per cycle; one root bit leaves.
               rem_ff  <= root_bit ? (TW+2)'(root_cat - root_trial) : (TW+2)'(root_cat);
               root_ff <= {root_ff[TW-2:0], root_bit};
               rad_ff  <= rad_ff << 2;
               if (cnt_ff == '0) begin
                  state_ff <= S_SETUP;
               end else begin
                  cnt_ff <= cnt_ff - CNTW'(1);
               end
            end
            S_SETUP: begin
               if (root_ff == '0) begin
                  term_ff  <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  // Adding the root before halving it rounds half away from zero.
                  xd_ff    <= (XW'(mag_ff) << 21) + XW'(root_ff);
                  dv_ff    <= {root_ff, 1'b0};
                  drem_ff  <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= CNTW'(XW - 1);
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               drem_ff <= div_bit ? DVW'(div_cat - {1'b0, dv_ff}) : DVW'(div_cat);
               q_ff    <= {q_ff[XW-2:0], div_bit};
               xd_ff   <= xd_ff << 1;
               if (cnt_ff == '0) begin
                  state_ff <= S_FINISH;
               end else begin
                  cnt_ff <= cnt_ff - CNTW'(1);
               end
            end
            S_FINISH: begin
               term_ff  <= neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign term = term_ff;
endmodule

@@ hw/rtl/tv_gradient_stencil.sv @@
// Streaming isotropic total-variation gradient over a raster image.
//
// Pixels enter on req_bus in raster order as signed Q8.8 words; command
// flush stands for a zero pixel. After the image, image_width+1 flush
// words drain the window. The first image_width+1 words give no result;
// from then on each word gives one rsp_bus word for the pixel one row plus
// one pixel back, with its row and column; last marks the final pixel.
// One word is worked on at a time: it passes through the line memories,
// then three terms run in turn on one shared unit, each with a square
// step, a sum step, a bit-serial root and a bit-serial division; a term
// with a zero numerator skips these steps, and a word without a result
// skips the terms.
// After reset the line memories are zeroed address by address, during
// which req_bus.ready stays low. A finished word sits in the output
// register; the next request is still taken while rsp_bus is stalled, and
// the block waits only when a second result is ready to go.
// The user must write the csr port only while idle; it is not enforced.
module tv_gradient_stencil #(
   parameter int MAX_WIDTH  = tvg_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = tvg_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tvg_req_if.sink                               req_bus,
   tvg_rsp_if.source                             rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic [tvg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tvg_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   localparam int WW  = $clog2(MAX_WIDTH+1);
   localparam int NW  = tvg_pkg::num_width(PIXEL_BITS);
   localparam int DW  = PIXEL_BITS + 1;
   localparam int OW  = tvg_pkg::term_width(PIXEL_BITS);
   localparam int ACW = OW + 2;
   localparam int DB  = tvg_pkg::DIM_BITS;
   localparam int GB  = tvg_pkg::GRAD_BITS;

   typedef enum logic [1:0] {T_IDLE, T_FRONT, T_TERM, T_OUT} state_type;

   logic [DB-1:0]                  width_ff, height_ff;
   logic [tvg_pkg::EPS_BITS-1:0]   eps_ff;
   logic [WW-1:0]                  w_eff;
   logic [DB-1:0]                  h_eff;

   state_type                      state_ff;
   logic [1:0]                     term_idx_ff;
   logic                           term_start_ff;
   logic signed [ACW-1:0]          acc_ff;
   logic                           rsp_valid_ff;
   logic signed [GB-1:0]           grad_ff;
   logic [tvg_pkg::POS_BITS-1:0]   row_ff, col_ff;
   logic                           last_ff;

   logic signed [PIXEL_BITS-1:0]   pix_ext, x_in;
   logic                           accept, clearing, lb_done, term_done, load_out;
   tvg_pkg::pos_type               info;
   logic signed [PIXEL_BITS-1:0]   p, up, ur, lf, rt, dn, dl;
   logic signed [NW-1:0]           num;
   logic signed [DW-1:0]           dx, dy;
   logic signed [OW-1:0]           term;
   logic signed [GB-1:0]           grad_sat;

   generate
      if (PIXEL_BITS <= tvg_pkg::PIXEL_IN_BITS) begin : g_narrow
         assign pix_ext = req_bus.pixel[PIXEL_BITS-1:0];
      end else begin : g_wide
         assign pix_ext = $signed({{(PIXEL_BITS-tvg_pkg::PIXEL_IN_BITS){1'b0}},
                                   req_bus.pixel});
      end
   endgenerate

   assign x_in    = (req_bus.command == tvg_pkg::CMD_FLUSH) ? '0 : pix_ext;
   assign req_bus.ready = (state_ff == T_IDLE) && !clearing;
   assign accept  = req_bus.valid && req_bus.ready;

   always_comb begin
      int iw;
      int ih;
      iw = int'(width_ff);
      ih = int'(height_ff);
      if (iw < 1) begin
         w_eff = WW'(1);
      end else if (iw > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(iw);
      end
      if (ih < 1) begin
         h_eff = DB'(1);
      end else if (ih > tvg_pkg::MAX_HEIGHT) begin
         h_eff = DB'(tvg_pkg::MAX_HEIGHT);
      end else begin
         h_eff = DB'(ih);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tvg_pkg::WIDTH_RESET;
         height_ff <= tvg_pkg::HEIGHT_RESET;
         eps_ff    <= tvg_pkg::EPSILON_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tvg_pkg::CSR_IMAGE_WIDTH:  width_ff  <= DB'(csr_data);
            tvg_pkg::CSR_IMAGE_HEIGHT: height_ff <= DB'(csr_data);
            tvg_pkg::CSR_EPSILON:      eps_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   tvg_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .x        (x_in),
      .w        (w_eff),
      .h        (h_eff),
      .clearing (clearing),
      .done     (lb_done),
      .info     (info),
      .p        (p),
      .up       (up),
      .ur       (ur),
      .lf       (lf),
      .rt       (rt),
      .dn       (dn),
      .dl       (dl)
   );

   // Operands of the term selected by the sequencer.
   always_comb begin
      logic signed [NW-1:0] pe, ue, ure, le, re, de, dle;
      pe = p; ue = up; ure = ur; le = lf; re = rt; de = dn; dle = dl;
      case (term_idx_ff)
         tvg_pkg::TERM_CENTER: begin
            num = (pe <<< 2) - (ue <<< 1) - (le <<< 1);
            dx  = DW'(pe - ue);
            dy  = DW'(pe - le);
         end
         tvg_pkg::TERM_DOWN: begin
            num = (pe - de) <<< 1;
            dx  = DW'(de - pe);
            dy  = DW'(de - dle);
         end
         tvg_pkg::TERM_RIGHT: begin
            num = (pe - re) <<< 1;
            dx  = DW'(re - pe);
            dy  = DW'(re - ure);
         end
         default: begin
            num = '0;
            dx  = '0;
            dy  = '0;
         end
      endcase
   end

   tvg_term #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_term (
      .clock   (clock),
      .reset   (reset),
      .start   (term_start_ff),
      .num     (num),
      .dx      (dx),
      .dy      (dy),
      .epsilon (eps_ff),
      .done    (term_done),
      .term    (term)
   );

   always_comb begin
      if (acc_ff > ACW'(32767)) begin
         grad_sat = 16'sh7FFF;
      end else if (acc_ff < -ACW'(32768)) begin
         grad_sat = 16'sh8000;
      end else begin
         grad_sat = acc_ff[GB-1:0];
      end
   end

   assign load_out = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         term_idx_ff   <= tvg_pkg::TERM_CENTER;
         term_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         term_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  state_ff <= T_FRONT;
               end
            end
            T_FRONT: begin
               if (lb_done) begin
                  if (info.emit) begin
                     term_idx_ff   <= tvg_pkg::TERM_CENTER;
                     term_start_ff <= 1'b1;
                     acc_ff        <= '0;
                     state_ff      <= T_TERM;
                  end else begin
                     state_ff <= T_IDLE;
                  end
               end
            end
            T_TERM: begin
               if (term_done) begin
                  acc_ff <= acc_ff + ACW'(term);
                  if (term_idx_ff == tvg_pkg::TERM_RIGHT) begin
                     state_ff <= T_OUT;
                  end else begin
                     term_idx_ff   <= term_idx_ff + 2'd1;
                     term_start_ff <= 1'b1;
                  end
               end
            end
            T_OUT: begin
               if (load_out) begin
                  rsp_valid_ff <= 1'b1;
                  grad_ff      <= grad_sat;
                  row_ff       <= info.row;
                  col_ff       <= info.column;
                  last_ff      <= info.last;
                  state_ff     <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.gradient = grad_ff;
   assign rsp_bus.row      = row_ff;
   assign rsp_bus.column   = col_ff;
   assign rsp_bus.last     = last_ff;
endmodule
